/* rtl/core/gjk_pkg.sv */
// Shared types, codes and the multiply-accumulate term table for the GJK simplex step.
`default_nettype none

package gjk_pkg;

   // Direction and wide intermediate width, and the stream field stride
   localparam int DIR_W   = 64;
   localparam int HALF_W  = 32;
   localparam int FIELD_W = 16;

   // Verdict codes
   localparam logic [1:0] VERDICT_CONT = 2'd0;
   localparam logic [1:0] VERDICT_SEP  = 2'd1;
   localparam logic [1:0] VERDICT_HIT  = 2'd2;

   // Opcodes on the request side
   localparam logic OP_START = 1'b0;
   localparam logic OP_ADD   = 1'b1;

   // Last issue step of each vector operation (two half products per term)
   localparam logic [3:0] DOT_LAST_STEP   = 4'd5;
   localparam logic [3:0] CROSS_LAST_STEP = 4'd11;

   typedef logic signed [DIR_W-1:0] dir_type;
   typedef logic [1:0] axis_type;

   typedef enum logic {
      VOP_DOT,
      VOP_CROSS
   } vop_type;

   typedef struct packed {
      logic    start;
      vop_type op;
      logic    neg;
   } vu_req_type;

   typedef struct packed {
      logic done;
      logic neg;
      logic pos;
   } vu_rsp_type;

   typedef struct packed {
      axis_type a_idx;
      axis_type b_idx;
      logic     sub;
      logic     first;
      logic     store;
      logic     last;
      axis_type comp;
   } term_type;

   typedef struct packed {
      logic     valid;
      logic     half;
      logic     sub;
      logic     first;
      logic     store;
      logic     last;
      axis_type comp;
   } stage_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SEP_DOT,
      ST_SETUP,
      ST_LINE_DOT,
      ST_LINE_X1,
      ST_LINE_X2,
      ST_TRI_ABC,
      ST_TRI_X1,
      ST_TRI_D1,
      ST_TRI_ACDOT,
      ST_TRI_X2,
      ST_TRI_D2,
      ST_TRI_D3,
      ST_TET_X,
      ST_TET_D,
      ST_DONE
   } state_type;

   // Term sequence: cross runs x, y, z as (first product minus second product);
   // dot sums the three axis products.
   function automatic term_type term_info(input vop_type op, input logic [2:0] term);
      term_type t;
      t = '{a_idx: 2'd0, b_idx: 2'd0, sub: 1'b0, first: 1'b0, store: 1'b0,
            last: 1'b0, comp: 2'd0};
      if (op == VOP_CROSS) begin
         unique case (term)
            3'd0: t = '{2'd1, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0};
            3'd1: t = '{2'd2, 2'd1, 1'b1, 1'b0, 1'b1, 1'b0, 2'd0};
            3'd2: t = '{2'd2, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 2'd1};
            3'd3: t = '{2'd0, 2'd2, 1'b1, 1'b0, 1'b1, 1'b0, 2'd1};
            3'd4: t = '{2'd0, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0, 2'd2};
            3'd5: t = '{2'd1, 2'd0, 1'b1, 1'b0, 1'b1, 1'b1, 2'd2};
            default: t = '{2'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0};
         endcase
      end else begin
         unique case (term)
            3'd0: t = '{2'd0, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0};
            3'd1: t = '{2'd1, 2'd1, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0};
            3'd2: t = '{2'd2, 2'd2, 1'b0, 1'b0, 1'b0, 1'b1, 2'd0};
            default: t = '{2'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0};
         endcase
      end
      return t;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/gjk_mac_unit.sv */
// Shared multiply-accumulate unit: cross and dot products of a wide by a narrow vector.
`default_nettype none

module gjk_mac_unit import gjk_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  vu_req_type               req,
   input  dir_type                  op_a [3],
   input  logic signed [COORD_BITS:0] op_b [3],
   output vu_rsp_type               rsp,
   output dir_type                  res [3]
);

   localparam int NW    = COORD_BITS + 1;
   localparam int PW    = HALF_W + 1 + NW;
   localparam int ACC_W = DIR_W + NW + 3;

   logic                     busy_ff, busy_in;
   logic [3:0]               step_ff, step_in;
   vop_type                  op_ff;
   logic                     neg_ff;
   dir_type                  a_ff [3];
   logic signed [NW-1:0]     b_ff [3];
   logic signed [PW-1:0]     prod_ff, prod_in;
   stage_type                ctl_ff, ctl_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_next;
   dir_type                  res_ff [3];
   logic                     done_ff, done_in;
   logic                     sneg_ff, spos_ff;

   term_type                 info;
   dir_type                  a_word;
   logic signed [HALF_W:0]   a_half;
   logic signed [NW-1:0]     b_sel;
   logic [3:0]               last_step;
   logic signed [ACC_W-1:0]  addend, add_val;

   // Issue one half product per cycle while busy
   always_comb begin
      info      = term_info(op_ff, step_ff[3:1]);
      a_word    = a_ff[info.a_idx];
      b_sel     = b_ff[info.b_idx];
      a_half    = step_ff[0] ? {a_word[DIR_W-1], a_word[DIR_W-1:HALF_W]}
                             : {1'b0, a_word[HALF_W-1:0]};
      prod_in   = PW'(a_half) * PW'(b_sel);
      last_step = (op_ff == VOP_DOT) ? DOT_LAST_STEP : CROSS_LAST_STEP;
      busy_in   = busy_ff;
      step_in   = step_ff;
      if (!busy_ff && req.start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         if (step_ff == last_step) begin
            busy_in = 1'b0;
         end
      end
      ctl_in = '{valid: busy_ff, half: step_ff[0], sub: info.sub ^ neg_ff,
                 first: info.first, store: info.store, last: info.last,
                 comp: info.comp};
   end

   // Accumulate the registered product, upper half shifted into place
   always_comb begin
      addend   = ACC_W'(prod_ff);
      if (ctl_ff.half) begin
         addend = addend <<< HALF_W;
      end
      add_val  = ctl_ff.sub ? -addend : addend;
      acc_next = (ctl_ff.first && !ctl_ff.half) ? add_val : acc_ff + add_val;
      done_in  = ctl_ff.valid && ctl_ff.last && ctl_ff.half;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         ctl_ff  <= ctl_in;
         done_ff <= done_in;
      end
   end

   // Operand, product and accumulator registers
   always_ff @(posedge clock) begin
      if (!busy_ff && req.start) begin
         op_ff  <= req.op;
         neg_ff <= req.neg;
         a_ff   <= op_a;
         b_ff   <= op_b;
      end
      prod_ff <= prod_in;
      if (ctl_ff.valid) begin
         acc_ff <= acc_next;
         if (ctl_ff.store && ctl_ff.half) begin
            res_ff[ctl_ff.comp] <= acc_next[DIR_W-1:0];
         end
      end
      if (done_in) begin
         sneg_ff <= acc_next[ACC_W-1];
         spos_ff <= !acc_next[ACC_W-1] && (acc_next != '0);
      end
   end

   assign rsp = '{done: done_ff, neg: sneg_ff, pos: spos_ff};
   assign res = res_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("unit done while still issuing");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= CROSS_LAST_STEP))
      else $error("unit step past the last term");
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      req.start |-> (!busy_ff && !ctl_ff.valid))
      else $error("unit started while busy");

endmodule

`default_nettype wire

/* rtl/core/gjk_simplex_step.sv */
// Top level of the GJK simplex step: request decode, region-test sequencer, result register.
//
// Usage: the caller sends one word per step on the req_ stream. req_tuser = 0 starts a
// new query with the point in req_tdata, req_tuser = 1 adds the support point found for
// the direction last returned. Every request gives exactly one rsp_ word holding the
// verdict (continue, separated, intersecting), the next search direction and the
// simplex size. Coordinates are sign-extended to COORD_BITS bits.
// For a start or a repeated verdict the sequencer goes from the accept straight to its
// done state, which loads the result register and raises rsp_tvalid. An add runs its dot
// and cross products one after another on one shared 33 x (COORD_BITS+1) bit multiplier,
// two half products per term, so its work ranges from the separation check alone up to
// a tetrahedron falling back to a triangle and then a line.
// One request is in work at a time; req_tready is high only while the sequencer is idle
// and the result register is empty, so the next word is taken at the earliest in the
// cycle after the result word is taken.
// Reset empties the simplex, aims the direction along +x and clears the verdict.
// A stalled receiver holds rsp_ as is and keeps req_tready low until the word is taken.
`default_nettype none

module gjk_simplex_step import gjk_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // support_x[15:0], support_y[31:16], support_z[47:32]
   input  logic         req_tuser,   // opcode[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata    // verdict[1:0], next_dir_x[65:2], next_dir_y[129:66],
                                     // next_dir_z[193:130], simplex_size[196:194], zero
);

   localparam int NW = COORD_BITS + 1;

   state_type               state_ff, state_in;
   logic [2:0]              count_ff, count_in;
   logic [1:0]              verdict_ff, verdict_in;
   dir_type                 dir_ff [3], dir_in [3];
   logic signed [COORD_BITS-1:0] pt_ff [4][3], pt_in [4][3];
   logic signed [COORD_BITS-1:0] inp_ff [3], inp_in [3];
   logic signed [COORD_BITS-1:0] pb_ff [3], pb_in [3];
   logic signed [COORD_BITS-1:0] pc_ff [3], pc_in [3];
   logic signed [COORD_BITS-1:0] pe_ff [3], pe_in [3];
   logic signed [NW-1:0]    u_ff [3], u_in [3];
   logic signed [NW-1:0]    v_ff [3], v_in [3];
   logic signed [NW-1:0]    e_ff [3], e_in [3];
   logic signed [NW-1:0]    ao_ff [3], ao_in [3];
   logic signed [NW-1:0]    dab_ff [3], dab_in [3];
   logic signed [NW-1:0]    dad_ff [3], dad_in [3];
   dir_type                 t1_ff [3], t1_in [3];
   dir_type                 t2_ff [3], t2_in [3];
   logic [1:0]              tq_ff, tq_in;
   logic                    issued_ff, issued_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [199:0]            rsp_data_ff, rsp_data_in;

   logic signed [COORD_BITS-1:0] req_pt [3];
   logic signed [FIELD_W-1:0]    req_field [3];
   logic                    accept;
   logic [2:0]              keep_n;
   vu_req_type              vu_req;
   vu_rsp_type              vu_rsp;
   dir_type                 vu_a [3];
   logic signed [NW-1:0]    vu_b [3];
   dir_type                 vu_res [3];

   gjk_mac_unit #(.COORD_BITS(COORD_BITS)) u_mac (
      .clock (clock),
      .reset (reset),
      .req   (vu_req),
      .op_a  (vu_a),
      .op_b  (vu_b),
      .rsp   (vu_rsp),
      .res   (vu_res)
   );

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign keep_n     = (count_ff > 3'd3) ? 3'd3 : count_ff;

   // Unpack and sign-extend the request point
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         req_field[i] = req_tdata[i*FIELD_W +: FIELD_W];
         req_pt[i]    = COORD_BITS'(req_field[i]);
      end
   end

   // Sequencer: next state, register updates and unit operands
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      verdict_in = verdict_ff;
      dir_in     = dir_ff;
      pt_in      = pt_ff;
      inp_in     = inp_ff;
      pb_in      = pb_ff;
      pc_in      = pc_ff;
      pe_in      = pe_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      e_in       = e_ff;
      ao_in      = ao_ff;
      dab_in     = dab_ff;
      dad_in     = dad_ff;
      t1_in      = t1_ff;
      t2_in      = t2_ff;
      tq_in      = tq_ff;
      issued_in  = issued_ff;
      vu_req     = '{start: 1'b0, op: VOP_DOT, neg: 1'b0};
      for (int i = 0; i < 3; i++) begin
         vu_a[i] = '0;
         vu_b[i] = '0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // Launch the unit once per compute state, clear the flag when it reports
      if (state_ff != ST_IDLE && state_ff != ST_SETUP && state_ff != ST_DONE) begin
         vu_req.start = !issued_ff;
         issued_in    = 1'b1;
         if (vu_rsp.done) begin
            issued_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DONE;
               if (req_tuser == OP_START) begin
                  pt_in[0]   = req_pt;
                  count_in   = 3'd1;
                  verdict_in = VERDICT_CONT;
                  for (int i = 0; i < 3; i++) begin
                     dir_in[i] = -DIR_W'(req_pt[i]);
                  end
               end else if (verdict_ff == VERDICT_CONT) begin
                  inp_in   = req_pt;
                  state_in = ST_SEP_DOT;
               end
            end
         end
         ST_SEP_DOT: begin
            vu_a = dir_ff;
            for (int i = 0; i < 3; i++) begin
               vu_b[i] = NW'(inp_ff[i]);
            end
            if (vu_rsp.done) begin
               if (vu_rsp.neg) begin
                  verdict_in = VERDICT_SEP;
                  state_in   = ST_DONE;
               end else begin
                  // Prepend the point, dropping the oldest when full
                  if (keep_n >= 3'd3) pt_in[3] = pt_ff[2];
                  if (keep_n >= 3'd2) pt_in[2] = pt_ff[1];
                  if (keep_n >= 3'd1) pt_in[1] = pt_ff[0];
                  pt_in[0] = inp_ff;
                  count_in = keep_n + 3'd1;
                  state_in = (keep_n == 3'd0) ? ST_DONE : ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            for (int i = 0; i < 3; i++) begin
               ao_in[i]  = -NW'(pt_ff[0][i]);
               dab_in[i] = NW'(pt_ff[1][i]) - NW'(pt_ff[0][i]);
               v_in[i]   = NW'(pt_ff[2][i]) - NW'(pt_ff[0][i]);
               dad_in[i] = NW'(pt_ff[3][i]) - NW'(pt_ff[0][i]);
            end
            u_in  = dab_in;
            e_in  = dab_in;
            pe_in = pt_ff[1];
            pb_in = pt_ff[1];
            pc_in = pt_ff[2];
            tq_in = 2'd0;
            priority case (count_ff)
               3'd2:    state_in = ST_LINE_DOT;
               3'd3:    state_in = ST_TRI_ABC;
               3'd4:    state_in = ST_TET_X;
               default: state_in = ST_DONE;
            endcase
         end
         ST_LINE_DOT: begin
            for (int i = 0; i < 3; i++) begin
               vu_a[i] = DIR_W'(e_ff[i]);
            end
            vu_b = ao_ff;
            if (vu_rsp.done) begin
               if (vu_rsp.pos) begin
                  state_in = ST_LINE_X1;
               end else begin
                  count_in = 3'd1;
                  for (int i = 0; i < 3; i++) begin
                     dir_in[i] = DIR_W'(ao_ff[i]);
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_LINE_X1: begin
            vu_req.op = VOP_CROSS;
            for (int i = 0; i < 3; i++) begin
               vu_a[i] = DIR_W'(e_ff[i]);
            end
            vu_b = ao_ff;
            if (vu_rsp.done) begin
               t1_in    = vu_res;
               state_in = ST_LINE_X2;
            end
         end
         ST_LINE_X2: begin
            vu_req.op = VOP_CROSS;
            vu_a      = t1_ff;
            vu_b      = e_ff;
            if (vu_rsp.done) begin
               dir_in   = vu_res;
               pt_in[1] = pe_ff;
               count_in = 3'd2;
               state_in = ST_DONE;
            end
         end
         ST_TRI_ABC: begin
            vu_req.op = VOP_CROSS;
            for (int i = 0; i < 3; i++) begin
               vu_a[i] = DIR_W'(u_ff[i]);
            end
            vu_b = v_ff;
            if (vu_rsp.done) begin
               t2_in    = vu_res;
               state_in = ST_TRI_X1;
            end
         end
         ST_TRI_X1: begin
            vu_req.op = VOP_CROSS;
            vu_a      = t2_ff;
            vu_b      = v_ff;
            if (vu_rsp.done) begin
               t1_in    = vu_res;
               state_in = ST_TRI_D1;
            end
         end
         ST_TRI_D1: begin
            vu_a = t1_ff;
            vu_b = ao_ff;
            if (vu_rsp.done) begin
               state_in = vu_rsp.pos ? ST_TRI_ACDOT : ST_TRI_X2;
            end
         end
         ST_TRI_ACDOT: begin
            for (int i = 0; i < 3; i++) begin
               vu_a[i] = DIR_W'(v_ff[i]);
            end
            vu_b = ao_ff;
            if (vu_rsp.done) begin
               if (vu_rsp.pos) begin
                  e_in     = v_ff;
                  pe_in    = pc_ff;
                  state_in = ST_LINE_X1;
               end else begin
                  e_in     = u_ff;
                  pe_in    = pb_ff;
                  state_in = ST_LINE_DOT;
               end
            end
         end
         ST_TRI_X2: begin
            // ab x abc taken as -(abc x ab)
            vu_req.op  = VOP_CROSS;
            vu_req.neg = 1'b1;
            vu_a       = t2_ff;
            vu_b       = u_ff;
            if (vu_rsp.done) begin
               t1_in    = vu_res;
               state_in = ST_TRI_D2;
            end
         end
         ST_TRI_D2: begin
            vu_a = t1_ff;
            vu_b = ao_ff;
            if (vu_rsp.done) begin
               if (vu_rsp.pos) begin
                  e_in     = u_ff;
                  pe_in    = pb_ff;
                  state_in = ST_LINE_DOT;
               end else begin
                  state_in = ST_TRI_D3;
               end
            end
         end
         ST_TRI_D3: begin
            vu_a = t2_ff;
            vu_b = ao_ff;
            if (vu_rsp.done) begin
               count_in = 3'd3;
               state_in = ST_DONE;
               if (vu_rsp.pos) begin
                  pt_in[1] = pb_ff;
                  pt_in[2] = pc_ff;
                  dir_in   = t2_ff;
               end else begin
                  pt_in[1] = pc_ff;
                  pt_in[2] = pb_ff;
                  for (int i = 0; i < 3; i++) begin
                     dir_in[i] = -t2_ff[i];
                  end
               end
            end
         end
         ST_TET_X: begin
            vu_req.op = VOP_CROSS;
            for (int i = 0; i < 3; i++) begin
               vu_a[i] = DIR_W'(u_ff[i]);
            end
            vu_b = v_ff;
            if (vu_rsp.done) begin
               t2_in    = vu_res;
               state_in = ST_TET_D;
            end
         end
         ST_TET_D: begin
            vu_a = t2_ff;
            vu_b = ao_ff;
            if (vu_rsp.done) begin
               if (vu_rsp.pos) begin
                  state_in = ST_TRI_ABC;
               end else if (tq_ff == 2'd2) begin
                  verdict_in = VERDICT_HIT;
                  state_in   = ST_DONE;
               end else begin
                  // Rotate to the next face: (ac, ad) then (ad, ab)
                  tq_in    = tq_ff + 2'd1;
                  u_in     = v_ff;
                  pb_in    = pc_ff;
                  if (tq_ff == 2'd0) begin
                     v_in  = dad_ff;
                     pc_in = pt_ff[3];
                  end else begin
                     v_in  = dab_ff;
                     pc_in = pt_ff[1];
                  end
                  state_in = ST_TET_X;
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {3'b000, count_ff, dir_ff[2], dir_ff[1], dir_ff[0], verdict_ff};
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         verdict_ff   <= VERDICT_CONT;
         dir_ff[0]    <= DIR_W'(1);
         dir_ff[1]    <= '0;
         dir_ff[2]    <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         verdict_ff   <= verdict_in;
         dir_ff       <= dir_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: simplex points, edges and intermediate vectors
   always_ff @(posedge clock) begin
      pt_ff       <= pt_in;
      inp_ff      <= inp_in;
      pb_ff       <= pb_in;
      pc_ff       <= pc_in;
      pe_ff       <= pe_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      e_ff        <= e_in;
      ao_ff       <= ao_in;
      dab_ff      <= dab_in;
      dad_ff      <= dad_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      tq_ff       <= tq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result pending while sequencer busy");
   a_hit_full: assert property (@(posedge clock) disable iff (reset)
      (verdict_ff == VERDICT_HIT) |-> (count_ff == 3'd4))
      else $error("intersection reported without a tetrahedron");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("simplex count out of range");
   a_done_in_op: assert property (@(posedge clock) disable iff (reset)
      vu_rsp.done |-> issued_ff)
      else $error("unit result with no operation launched");

endmodule

`default_nettype wire
